### src/single_wire_sensor_pulse_decoder_core_macros.svh
// Assertion helpers shared by the decoder modules.
// All of them sample on aclk and are disabled while aresetn is low.
`ifndef SINGLE_WIRE_SENSOR_PULSE_DECODER_CORE_MACROS_SVH
`define SINGLE_WIRE_SENSOR_PULSE_DECODER_CORE_MACROS_SVH

// Property that must hold at every edge.
`define SWSPD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// Same-cycle implication.
`define SWSPD_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SWSPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/swspd_pkg.sv
`default_nettype none

package swspd_pkg;

    // Number of start positions tested for the start/sync pattern.
    localparam int unsigned SYNC_POSITIONS = 5;

    localparam int unsigned BIT_COUNT = 40;
    localparam int unsigned BIT_IDX_W = 6;
    localparam int unsigned EDGE_W    = 7;
    localparam int unsigned IVL_W     = 16;

    localparam logic [EDGE_W-1:0] EDGES_MIN = 7'd85;
    localparam logic [EDGE_W-1:0] EDGES_MAX = 7'd87;
    localparam logic [EDGE_W-1:0] EDGE_SAT  = 7'd127;

    // Interval k completes the test of start position k - SYNC_FIRST_POS.
    localparam logic [EDGE_W-1:0] SYNC_FIRST_POS = 7'd3;
    localparam logic [EDGE_W-1:0] SYNC_LAST_EXCL = EDGE_W'(3 + SYNC_POSITIONS);

    localparam logic [IVL_W-1:0] ZERO_HIGH_MIN = 16'd6;
    localparam logic [IVL_W-1:0] ONE_HIGH_MAX  = 16'd90;

    localparam logic [BIT_IDX_W-1:0] BIT_COUNT_V = BIT_IDX_W'(BIT_COUNT);
    localparam logic [BIT_IDX_W-1:0] BIT_TOP_V   = BIT_IDX_W'(BIT_COUNT - 1);

    localparam logic [IVL_W-1:0] RST_START_MIN     = 16'd19000;
    localparam logic [IVL_W-1:0] RST_START_MAX     = 16'd21000;
    localparam logic [IVL_W-1:0] RST_SYNC_MIN      = 16'd50;
    localparam logic [IVL_W-1:0] RST_SYNC_MAX      = 16'd100;
    localparam logic [IVL_W-1:0] RST_BIT_LOW_MIN   = 16'd30;
    localparam logic [IVL_W-1:0] RST_BIT_LOW_MAX   = 16'd70;
    localparam logic [IVL_W-1:0] RST_ZERO_HIGH_MAX = 16'd46;
    localparam logic [IVL_W-1:0] RST_ONE_HIGH_MIN  = 16'd50;

    // Queue between classifier and decoder.
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_INTERVAL = 1'b0;
    localparam logic CMD_END      = 1'b1;

    localparam int unsigned CFG_IDX_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_MIN     = 4'd0,
        REG_START_MAX     = 4'd1,
        REG_SYNC_MIN      = 4'd2,
        REG_SYNC_MAX      = 4'd3,
        REG_BIT_LOW_MIN   = 4'd4,
        REG_BIT_LOW_MAX   = 4'd5,
        REG_ZERO_HIGH_MAX = 4'd6,
        REG_ONE_HIGH_MIN  = 4'd7
    } cfg_reg_e;

    typedef enum logic [2:0] {
        ERR_OK       = 3'd0,
        ERR_EDGES    = 3'd1,
        ERR_NO_SYNC  = 3'd2,
        ERR_TIMING   = 3'd3,
        ERR_CHECKSUM = 3'd4
    } err_e;

    typedef struct packed {
        logic             command;
        logic [IVL_W-1:0] interval_us;
    } in_t;

    typedef struct packed {
        logic [15:0]       humidity_raw;
        logic [15:0]       temperature_raw;
        logic [7:0]        checksum_rx;
        logic              frame_valid;
        logic [2:0]        error_code;
        logic [EDGE_W-1:0] edges_seen;
    } out_t;

    typedef struct packed {
        logic [IVL_W-1:0] start_min_us;
        logic [IVL_W-1:0] start_max_us;
        logic [IVL_W-1:0] sync_min_us;
        logic [IVL_W-1:0] sync_max_us;
        logic [IVL_W-1:0] bit_low_min_us;
        logic [IVL_W-1:0] bit_low_max_us;
        logic [IVL_W-1:0] zero_high_max_us;
        logic [IVL_W-1:0] one_high_min_us;
    } cfg_t;

    // Classified transaction passed from front to back.
    typedef struct packed {
        logic             is_end;
        logic [IVL_W-1:0] interval_us;
        logic             sync_ok;
        logic             zero_ok;
        logic             one_ok;
    } cls_t;

endpackage

`default_nettype wire

### src/single_wire_sensor_pulse_decoder_core.sv
// Single-wire sensor pulse decoder.
// s_ channel: one transaction per edge interval (command 0, interval_us in
//   microseconds) or an end-of-capture marker (command 1).
// m_ channel: one transaction per end marker with humidity, raw temperature,
//   checksum byte, frame_valid, error_code and the edge count of the capture.
// cfg_ channel: 16-bit timing window registers, indexes 0..7; always ready,
//   unknown indexes ignored. Write only while no capture is in flight.
// Throughput: one transaction per cycle on s_ while s_ready is high. Each interval
//   is classified in the front register stage and applied by the back decoder.
// Result path: an end marker passes the front register, then a queue entry;
//   the back loads the output register on the cycle it pops the marker.
// Reset (aresetn low, synchronous): capture state cleared, timing windows
//   back to defaults, queue and output register empty.
// Stall: a result waits in the output register; intervals keep flowing past
//   it. A second end marker waits in the queue, the queue fills, and s_ready
//   drops until m_ready frees the output register.
`default_nettype none

module single_wire_sensor_pulse_decoder_core
    import swspd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire in_t                  s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output out_t                      m_data,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [IVL_W-1:0]     cfg_data
);

    cfg_t cfg;
    logic f_valid;
    logic f_ready;
    cls_t f_data;
    logic q_valid;
    logic q_ready;
    cls_t q_data;

    // Timing window registers.
    swspd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Front: takes transactions and tags each interval against the windows.
    swspd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .f_valid (f_valid),
        .f_ready (f_ready),
        .f_data  (f_data)
    );

    // Decouples front from back so each side can stall on its own.
    swspd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_data  (q_data)
    );

    // Back: sync search, bit decode, result build and output register.
    swspd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_data  (q_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

### src/swspd_cfg.sv
`default_nettype none

module swspd_cfg
    import swspd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [IVL_W-1:0]     cfg_data,
    output cfg_t                      cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_reg_e'(cfg_index))
                REG_START_MIN:     cfg_next.start_min_us     = cfg_data;
                REG_START_MAX:     cfg_next.start_max_us     = cfg_data;
                REG_SYNC_MIN:      cfg_next.sync_min_us      = cfg_data;
                REG_SYNC_MAX:      cfg_next.sync_max_us      = cfg_data;
                REG_BIT_LOW_MIN:   cfg_next.bit_low_min_us   = cfg_data;
                REG_BIT_LOW_MAX:   cfg_next.bit_low_max_us   = cfg_data;
                REG_ZERO_HIGH_MAX: cfg_next.zero_high_max_us = cfg_data;
                REG_ONE_HIGH_MIN:  cfg_next.one_high_min_us  = cfg_data;
                default:           cfg_next = cfg_reg;  // unknown index: dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_min_us     <= RST_START_MIN;
            cfg_reg.start_max_us     <= RST_START_MAX;
            cfg_reg.sync_min_us      <= RST_SYNC_MIN;
            cfg_reg.sync_max_us      <= RST_SYNC_MAX;
            cfg_reg.bit_low_min_us   <= RST_BIT_LOW_MIN;
            cfg_reg.bit_low_max_us   <= RST_BIT_LOW_MAX;
            cfg_reg.zero_high_max_us <= RST_ZERO_HIGH_MAX;
            cfg_reg.one_high_min_us  <= RST_ONE_HIGH_MIN;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### src/swspd_front.sv
`default_nettype none

module swspd_front
    import swspd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire in_t  s_data,
    output logic      f_valid,
    input  wire logic f_ready,
    output cls_t      f_data
);

    logic f_valid_reg;
    logic f_valid_next;
    cls_t f_data_reg;
    cls_t cls;

    // Comparisons that depend only on the new interval.
    always_comb begin
        cls.is_end      = (s_data.command == CMD_END);
        cls.interval_us = s_data.interval_us;
        cls.sync_ok     = (s_data.interval_us > cfg.sync_min_us) &&
                          (s_data.interval_us < cfg.sync_max_us);
        cls.zero_ok     = (s_data.interval_us >= ZERO_HIGH_MIN) &&
                          (s_data.interval_us <= cfg.zero_high_max_us);
        cls.one_ok      = (s_data.interval_us >= cfg.one_high_min_us) &&
                          (s_data.interval_us <= ONE_HIGH_MAX);
    end

    assign s_ready = !f_valid_reg || f_ready;
    assign f_valid = f_valid_reg;
    assign f_data  = f_data_reg;

    always_comb begin
        f_valid_next = f_valid_reg;
        if (s_valid && s_ready) begin
            f_valid_next = 1'b1;
        end else if (f_ready) begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            f_data_reg <= cls;
        end
    end

endmodule

`default_nettype wire

### src/swspd_queue.sv
`default_nettype none

module swspd_queue
    import swspd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cls_t in_data,
    output logic      out_valid,
    input  wire logic out_ready,
    output cls_t      out_data
);

    cls_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

### src/swspd_back.sv
`default_nettype none

`include "single_wire_sensor_pulse_decoder_core_macros.svh"

module swspd_back
    import swspd_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire cfg_t cfg,
    input  wire logic q_valid,
    output logic      q_ready,
    input  wire cls_t q_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output out_t      m_data
);

    logic [IVL_W-1:0]     recent0_reg, recent0_next;
    logic [IVL_W-1:0]     recent1_reg, recent1_next;
    logic [IVL_W-1:0]     recent2_reg, recent2_next;
    logic [EDGE_W-1:0]    edge_count_reg, edge_count_next;
    logic                 sync_found_reg, sync_found_next;
    logic [BIT_COUNT-1:0] bits_reg, bits_next;      // MSB-aligned decoded bits
    logic [BIT_IDX_W-1:0] bit_index_reg, bit_index_next;
    logic [IVL_W-1:0]     pending_low_reg, pending_low_next;
    logic                 phase_high_reg, phase_high_next;
    logic                 timing_err_reg, timing_err_next;
    logic                 m_valid_reg, m_valid_next;
    out_t                 m_data_reg, m_data_next;

    logic                 out_free;
    logic                 pop;
    logic                 pop_end;
    logic                 pop_ivl;
    logic                 in_window;
    logic                 pattern_ok;
    logic                 low_ok;
    logic                 is_zero;
    logic                 is_one;
    logic [BIT_IDX_W-1:0] bit_pos;
    logic [7:0]           sum;
    err_e                 err;

    assign out_free = !m_valid_reg || m_ready;
    assign q_ready  = !q_data.is_end || out_free;
    assign pop      = q_valid && q_ready;
    assign pop_end  = pop && q_data.is_end;
    assign pop_ivl  = pop && !q_data.is_end;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign in_window  = (edge_count_reg >= SYNC_FIRST_POS) && (edge_count_reg < SYNC_LAST_EXCL);
    assign pattern_ok = (recent2_reg > cfg.start_min_us) && (recent2_reg < cfg.start_max_us) &&
                        (recent0_reg > cfg.sync_min_us) && (recent0_reg < cfg.sync_max_us) &&
                        q_data.sync_ok;
    assign low_ok     = (pending_low_reg >= cfg.bit_low_min_us) &&
                        (pending_low_reg <= cfg.bit_low_max_us);
    assign is_zero    = low_ok && q_data.zero_ok;
    assign is_one     = low_ok && q_data.one_ok && !q_data.zero_ok;
    assign bit_pos    = BIT_TOP_V - bit_index_reg;

    // Result of an end command.
    assign sum = 8'(bits_reg[39:32] + bits_reg[31:24] + bits_reg[23:16] + bits_reg[15:8]);

    always_comb begin
        if (edge_count_reg < EDGES_MIN || edge_count_reg > EDGES_MAX) begin
            err = ERR_EDGES;
        end else if (!sync_found_reg) begin
            err = ERR_NO_SYNC;
        end else if (timing_err_reg || bit_index_reg < BIT_COUNT_V) begin
            err = ERR_TIMING;
        end else if (sum != bits_reg[7:0]) begin
            err = ERR_CHECKSUM;
        end else begin
            err = ERR_OK;
        end
    end

    always_comb begin
        recent0_next     = recent0_reg;
        recent1_next     = recent1_reg;
        recent2_next     = recent2_reg;
        edge_count_next  = edge_count_reg;
        sync_found_next  = sync_found_reg;
        bits_next        = bits_reg;
        bit_index_next   = bit_index_reg;
        pending_low_next = pending_low_reg;
        phase_high_next  = phase_high_reg;
        timing_err_next  = timing_err_reg;
        m_valid_next     = m_valid_reg;
        m_data_next      = m_data_reg;

        if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (pop_ivl) begin
            if (edge_count_reg != EDGE_SAT) begin
                edge_count_next = edge_count_reg + 1'b1;
            end
            if (!sync_found_reg) begin
                if (in_window && pattern_ok) begin
                    sync_found_next = 1'b1;
                    bit_index_next  = '0;
                    phase_high_next = 1'b0;
                    bits_next       = '0;
                end
                recent2_next = recent1_reg;
                recent1_next = recent0_reg;
                recent0_next = q_data.interval_us;
            end else if (bit_index_reg < BIT_COUNT_V) begin
                if (!phase_high_reg) begin
                    pending_low_next = q_data.interval_us;
                    phase_high_next  = 1'b1;
                end else begin
                    bits_next[bit_pos] = is_one;
                    if (!is_zero && !is_one) begin
                        timing_err_next = 1'b1;
                    end
                    bit_index_next  = bit_index_reg + 1'b1;
                    phase_high_next = 1'b0;
                end
            end
        end

        if (pop_end) begin
            m_valid_next                = 1'b1;
            m_data_next.frame_valid     = (err == ERR_OK);
            m_data_next.error_code      = err;
            m_data_next.edges_seen      = edge_count_reg;
            if (err == ERR_EDGES || err == ERR_NO_SYNC) begin
                m_data_next.humidity_raw    = '0;
                m_data_next.temperature_raw = '0;
                m_data_next.checksum_rx     = '0;
            end else begin
                m_data_next.humidity_raw    = bits_reg[39:24];
                m_data_next.temperature_raw = bits_reg[23:8];
                m_data_next.checksum_rx     = bits_reg[7:0];
            end
            recent0_next     = '0;
            recent1_next     = '0;
            recent2_next     = '0;
            edge_count_next  = '0;
            sync_found_next  = 1'b0;
            bits_next        = '0;
            bit_index_next   = '0;
            pending_low_next = '0;
            phase_high_next  = 1'b0;
            timing_err_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            recent0_reg     <= '0;
            recent1_reg     <= '0;
            recent2_reg     <= '0;
            edge_count_reg  <= '0;
            sync_found_reg  <= 1'b0;
            bits_reg        <= '0;
            bit_index_reg   <= '0;
            pending_low_reg <= '0;
            phase_high_reg  <= 1'b0;
            timing_err_reg  <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            recent0_reg     <= recent0_next;
            recent1_reg     <= recent1_next;
            recent2_reg     <= recent2_next;
            edge_count_reg  <= edge_count_next;
            sync_found_reg  <= sync_found_next;
            bits_reg        <= bits_next;
            bit_index_reg   <= bit_index_next;
            pending_low_reg <= pending_low_next;
            phase_high_reg  <= phase_high_next;
            timing_err_reg  <= timing_err_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    `SWSPD_ASSERT_ALWAYS(a_bit_index_range, bit_index_reg <= BIT_COUNT_V, "bit index past 40")
    `SWSPD_ASSERT_IMP(a_high_needs_sync, phase_high_reg, sync_found_reg, "high phase without sync")
    `SWSPD_ASSERT_NEXT(a_end_gives_result, pop_end, m_valid_reg, "end command lost its result")
    `SWSPD_ASSERT_IMP(a_valid_matches_err, m_valid_reg,
        m_data_reg.frame_valid == (m_data_reg.error_code == ERR_OK), "frame_valid mismatch")

endmodule

`default_nettype wire
